// File: sv/gtt_pkg.sv
// ----------------------------------------------------------------------------
// gtt_pkg
// shared constants, codes and types of the greedy iou track table
// ----------------------------------------------------------------------------
package gtt_pkg;

  localparam int MAX_TRACKS_DEF = 32;
  localparam int COORD_BITS_DEF = 12;
  localparam int ID_BITS_DEF    = 16;

  localparam int THR_BITS   = 16;
  localparam int MISS_BITS  = 10;
  localparam int CLASS_BITS = 8;

  localparam logic [THR_BITS-1:0]  THR_RESET        = 16'd32768;
  localparam logic [MISS_BITS-1:0] MISS_LIMIT_RESET = 10'd5;
  localparam logic [MISS_BITS-1:0] MISS_SAT         = 10'h3FF;

  // request commands
  localparam logic [1:0] CMD_DETECT    = 2'd0;
  localparam logic [1:0] CMD_END_FRAME = 2'd1;
  localparam logic [1:0] CMD_QUERY     = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_DETECT = 2'd0;
  localparam logic [1:0] KIND_LIST   = 2'd1;
  localparam logic [1:0] KIND_QUERY  = 2'd2;

  // result status
  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_NEW  = 2'd1;
  localparam logic [1:0] STAT_DROP = 2'd2;
  localparam logic [1:0] STAT_NONE = 2'd3;

  // configuration register indexes
  localparam logic CFG_IOU_THRESHOLD = 1'b0;
  localparam logic CFG_MAX_MISSING   = 1'b1;

  typedef struct packed {
    logic id_we;
    logic box_we;
    logic miss_we;
  } gtt_wr_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DA,
    S_D_SCAN,
    S_D_GEOM,
    S_MI,
    S_MA,
    S_MU,
    S_MT,
    S_MC,
    S_MP,
    S_MQ,
    S_D_DONE,
    S_E_SCAN,
    S_E_AGE,
    S_L_SCAN,
    S_L_CHK,
    S_L_RD,
    S_L_OUT,
    S_L_EMPTY,
    S_Q_SCAN,
    S_Q_CHK,
    S_Q_OUT,
    S_Q_NONE
  } st_e;

endpackage

// File: sv/gtt_mul.sv
// ----------------------------------------------------------------------------
// gtt_mul
// shared unsigned multiplier with a registered product
// ----------------------------------------------------------------------------
module gtt_mul #(
  parameter int W = 25
) (
  input  logic           clk_i,
  input  logic [W-1:0]   a_i,
  input  logic [W-1:0]   b_i,
  output logic [2*W-1:0] p_o
);

  logic [2*W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

// File: sv/gtt_slot_mem.sv
// ----------------------------------------------------------------------------
// gtt_slot_mem
// per-slot track storage: id, box with class, missing count
// ----------------------------------------------------------------------------
module gtt_slot_mem
  import gtt_pkg::*;
#(
  parameter int MAX_TRACKS = MAX_TRACKS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int ID_BITS    = ID_BITS_DEF,
  parameter int IW         = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1
) (
  input  logic                    clk_i,
  input  gtt_wr_t                 wr_i,
  input  logic [IW-1:0]           wr_addr_i,
  input  logic [ID_BITS-1:0]      wr_id_i,
  input  logic [4*COORD_BITS-1:0] wr_box_i,
  input  logic [CLASS_BITS-1:0]   wr_cls_i,
  input  logic [MISS_BITS-1:0]    wr_miss_i,
  input  logic [IW-1:0]           rd_addr_i,
  output logic [ID_BITS-1:0]      rd_id_o,
  output logic [4*COORD_BITS-1:0] rd_box_o,
  output logic [CLASS_BITS-1:0]   rd_cls_o,
  output logic [MISS_BITS-1:0]    rd_miss_o
);

  localparam int BCW = 4*COORD_BITS + CLASS_BITS;

  logic [ID_BITS-1:0]   id_mem   [MAX_TRACKS];
  logic [BCW-1:0]       box_mem  [MAX_TRACKS];
  logic [MISS_BITS-1:0] miss_mem [MAX_TRACKS];
  logic [BCW-1:0]       box_rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.id_we) begin
      id_mem[wr_addr_i] <= wr_id_i;
    end
    if (wr_i.box_we) begin
      box_mem[wr_addr_i] <= {wr_cls_i, wr_box_i};
    end
    if (wr_i.miss_we) begin
      miss_mem[wr_addr_i] <= wr_miss_i;
    end
    rd_id_o   <= id_mem[rd_addr_i];
    box_rd_q  <= box_mem[rd_addr_i];
    rd_miss_o <= miss_mem[rd_addr_i];
  end

  assign rd_box_o = box_rd_q[4*COORD_BITS-1:0];
  assign rd_cls_o = box_rd_q[BCW-1:4*COORD_BITS];

endmodule

// File: sv/iou_greedy_track_table.sv
// ----------------------------------------------------------------------------
// iou_greedy_track_table
// greedy iou tracker over a small table of boxes with one shared multiplier
// ----------------------------------------------------------------------------
// One request is worked at a time; in_stall_o stays high until its last result
// sits in the output register. A detection first takes its area, then walks
// every slot: an empty slot is passed over, a valid slot that is already
// touched or does not overlap is only checked, and an overlapping untouched
// track is scored (the intersection, area, threshold and cross-products all
// go through the single multiplier); then it answers. End of frame ages every
// valid untouched slot, then lists n survivors by n selection passes over the
// slots, lowest id first. A query scans the slots for its id. The slot
// memories are read one slot a cycle and need no clearing after reset.
module iou_greedy_track_table
  import gtt_pkg::*;
#(
  parameter int MAX_TRACKS = MAX_TRACKS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int ID_BITS    = ID_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic                  cfg_index_i,
  input  logic [THR_BITS-1:0]   cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [1:0]            cmd_i,
  input  logic [COORD_BITS-1:0] box_x_i,
  input  logic [COORD_BITS-1:0] box_y_i,
  input  logic [COORD_BITS-1:0] box_w_i,
  input  logic [COORD_BITS-1:0] box_h_i,
  input  logic [CLASS_BITS-1:0] class_id_i,
  input  logic [ID_BITS-1:0]    query_id_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [1:0]            kind_o,
  output logic [1:0]            status_o,
  output logic [ID_BITS-1:0]    track_id_o,
  output logic [COORD_BITS-1:0] out_x_o,
  output logic [COORD_BITS-1:0] out_y_o,
  output logic [COORD_BITS-1:0] out_w_o,
  output logic [COORD_BITS-1:0] out_h_o,
  output logic [COORD_BITS+1:0] center_x2_o,
  output logic [COORD_BITS+1:0] center_y2_o,
  output logic [MISS_BITS-1:0]  missing_count_o,
  output logic [CLASS_BITS-1:0] out_class_o,
  output logic                  last_o
);

  localparam int IW = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
  localparam int CW = IW + 1;
  localparam int CB = COORD_BITS;
  localparam int XW = CB + 1;
  localparam int MW = 2*CB + 1;
  localparam int PW = 2*MW;
  localparam int BW = 4*CB;

  st_e state_q, state_d;

  logic [CW-1:0]         idx_q;
  logic [CB-1:0]         det_x_q, det_y_q, det_w_q, det_h_q;
  logic [CLASS_BITS-1:0] det_cls_q;
  logic [ID_BITS-1:0]    qid_q;
  logic [THR_BITS-1:0]   thr_q;
  logic [MISS_BITS-1:0]  maxm_q;
  logic [MAX_TRACKS-1:0] valid_q, seen_q, listed_q;
  logic [ID_BITS-1:0]    next_id_q;
  logic [MW-1:0]         da_q, inter_q, uni_q, best_i_q, best_u_q;
  logic [CB-1:0]         dx_q, dy_q;
  logic [PW-1:0]         p1_q;
  logic                  best_found_q, coll_found_q, min_found_q;
  logic [IW-1:0]         best_slot_q, coll_slot_q, min_slot_q;
  logic [ID_BITS-1:0]    best_id_q, min_id_q;

  logic                  out_valid_q;
  logic [1:0]            kind_q, status_q;
  logic [ID_BITS-1:0]    id_q;
  logic [CB-1:0]         ox_q, oy_q, ow_q, oh_q;
  logic [CB+1:0]         cx_q, cy_q;
  logic [MISS_BITS-1:0]  omiss_q;
  logic [CLASS_BITS-1:0] ocls_q;
  logic                  olast_q;

  // memory and multiplier hookup
  gtt_wr_t               wr;
  logic [IW-1:0]         wr_addr;
  logic [ID_BITS-1:0]    wr_id;
  logic [MISS_BITS-1:0]  wr_miss;
  logic [ID_BITS-1:0]    rd_id;
  logic [BW-1:0]         rd_box;
  logic [CLASS_BITS-1:0] rd_cls;
  logic [MISS_BITS-1:0]  rd_miss;
  logic [MW-1:0]         mul_a, mul_b;
  logic [PW-1:0]         mul_p;

  logic [IW-1:0] slot;
  logic          in_acc, out_free, idx_end, cur_valid, cur_seen;
  logic          any_free, has_slot, overlap, thr_pass, better, evict, remaining;
  logic [IW-1:0] first_free, new_slot;
  logic [CB-1:0] t_x, t_y, t_w, t_h;
  logic [XW-1:0] d_ex, d_ey, t_ex, t_ey, x0, y0, x1, y1;
  logic [XW-1:0] dxw, dyw;
  logic [MISS_BITS:0] miss_inc;
  logic [MISS_BITS-1:0] miss_sat;
  logic          idx_inc, idx_clr, idx_load;

  logic                  emit;
  logic [1:0]            em_kind, em_status;
  logic [ID_BITS-1:0]    em_id;
  logic [CB-1:0]         em_x, em_y, em_w, em_h;
  logic [MISS_BITS-1:0]  em_miss;
  logic [CLASS_BITS-1:0] em_cls;
  logic                  em_last;

  assign slot      = idx_q[IW-1:0];
  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc    = in_valid_i && !in_stall_o;
  assign out_free  = !out_valid_q || !out_stall_i;
  assign idx_end   = (idx_q == CW'(MAX_TRACKS));
  assign cur_valid = valid_q[slot];
  assign cur_seen  = seen_q[slot];
  assign cfg_ready_o = 1'b1;

  gtt_slot_mem #(
    .MAX_TRACKS (MAX_TRACKS),
    .COORD_BITS (COORD_BITS),
    .ID_BITS    (ID_BITS),
    .IW         (IW)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_i      (wr),
    .wr_addr_i (wr_addr),
    .wr_id_i   (wr_id),
    .wr_box_i  ({det_h_q, det_w_q, det_y_q, det_x_q}),
    .wr_cls_i  (det_cls_q),
    .wr_miss_i (wr_miss),
    .rd_addr_i (slot),
    .rd_id_o   (rd_id),
    .rd_box_o  (rd_box),
    .rd_cls_o  (rd_cls),
    .rd_miss_o (rd_miss)
  );

  gtt_mul #(.W(MW)) u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  // overlap of the detection with the slot read out
  assign t_x  = rd_box[CB-1:0];
  assign t_y  = rd_box[2*CB-1:CB];
  assign t_w  = rd_box[3*CB-1:2*CB];
  assign t_h  = rd_box[4*CB-1:3*CB];
  assign d_ex = XW'(det_x_q) + XW'(det_w_q);
  assign d_ey = XW'(det_y_q) + XW'(det_h_q);
  assign t_ex = XW'(t_x) + XW'(t_w);
  assign t_ey = XW'(t_y) + XW'(t_h);
  assign x0   = (det_x_q > t_x) ? XW'(det_x_q) : XW'(t_x);
  assign y0   = (det_y_q > t_y) ? XW'(det_y_q) : XW'(t_y);
  assign x1   = (d_ex < t_ex) ? d_ex : t_ex;
  assign y1   = (d_ey < t_ey) ? d_ey : t_ey;
  assign overlap = (x1 > x0) && (y1 > y0);
  assign dxw  = x1 - x0;
  assign dyw  = y1 - y0;

  assign thr_pass = (PW'(inter_q) << THR_BITS) > mul_p;
  assign better   = (p1_q > mul_p) || ((p1_q == mul_p) && (rd_id < best_id_q));

  assign miss_inc = {1'b0, rd_miss} + (MISS_BITS+1)'(1);
  assign evict    = miss_inc > {1'b0, maxm_q};
  assign miss_sat = miss_inc[MISS_BITS] ? MISS_SAT : miss_inc[MISS_BITS-1:0];

  assign remaining = |(valid_q & ~listed_q &
                       ~({{(MAX_TRACKS-1){1'b0}}, 1'b1} << min_slot_q));

  always_comb begin
    any_free   = 1'b0;
    first_free = '0;
    for (int i = MAX_TRACKS-1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        any_free   = 1'b1;
        first_free = IW'(i);
      end
    end
  end

  assign has_slot = coll_found_q || any_free;
  assign new_slot = coll_found_q ? coll_slot_q : first_free;

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_IDLE: begin
        mul_a = MW'(box_w_i);
        mul_b = MW'(box_h_i);
      end
      S_MI: begin
        mul_a = MW'(dx_q);
        mul_b = MW'(dy_q);
      end
      S_MA: begin
        mul_a = MW'(t_w);
        mul_b = MW'(t_h);
      end
      S_MT: begin
        mul_a = MW'(thr_q);
        mul_b = uni_q;
      end
      S_MC: begin
        mul_a = inter_q;
        mul_b = best_u_q;
      end
      S_MP: begin
        mul_a = best_i_q;
        mul_b = uni_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_d   = state_q;
    idx_inc   = 1'b0;
    idx_clr   = 1'b0;
    idx_load  = 1'b0;
    wr        = '0;
    wr_addr   = slot;
    wr_id     = next_id_q;
    wr_miss   = '0;
    emit      = 1'b0;
    em_kind   = KIND_DETECT;
    em_status = STAT_OK;
    em_id     = '0;
    em_x      = '0;
    em_y      = '0;
    em_w      = '0;
    em_h      = '0;
    em_miss   = '0;
    em_cls    = '0;
    em_last   = 1'b1;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          idx_clr = 1'b1;
          case (cmd_i)
            CMD_DETECT:    state_d = S_DA;
            CMD_END_FRAME: state_d = S_E_SCAN;
            CMD_QUERY:     state_d = S_Q_SCAN;
            default:       state_d = S_IDLE;
          endcase
        end
      end
      S_DA: state_d = S_D_SCAN;
      S_D_SCAN: begin
        if (idx_end) begin
          state_d = S_D_DONE;
        end else if (cur_valid) begin
          state_d = S_D_GEOM;
        end else begin
          idx_inc = 1'b1;
        end
      end
      S_D_GEOM: begin
        if (cur_seen || !overlap) begin
          idx_inc = 1'b1;
          state_d = S_D_SCAN;
        end else begin
          state_d = S_MI;
        end
      end
      S_MI: state_d = S_MA;
      S_MA: state_d = S_MU;
      S_MU: state_d = S_MT;
      S_MT: state_d = S_MC;
      S_MC: begin
        if (thr_pass && best_found_q) begin
          state_d = S_MP;
        end else begin
          idx_inc = 1'b1;
          state_d = S_D_SCAN;
        end
      end
      S_MP: state_d = S_MQ;
      S_MQ: begin
        idx_inc = 1'b1;
        state_d = S_D_SCAN;
      end
      S_D_DONE: begin
        em_kind = KIND_DETECT;
        em_x    = det_x_q;
        em_y    = det_y_q;
        em_w    = det_w_q;
        em_h    = det_h_q;
        em_cls  = det_cls_q;
        if (best_found_q) begin
          em_status = STAT_OK;
          em_id     = best_id_q;
          wr_addr   = best_slot_q;
        end else if (has_slot) begin
          em_status = STAT_NEW;
          em_id     = next_id_q;
          wr_addr   = new_slot;
        end else begin
          em_status = STAT_DROP;
        end
        if (out_free) begin
          emit       = 1'b1;
          wr.box_we  = best_found_q || has_slot;
          wr.miss_we = best_found_q || has_slot;
          wr.id_we   = !best_found_q && has_slot;
          state_d    = S_IDLE;
        end
      end
      S_E_SCAN: begin
        if (idx_end) begin
          idx_clr = 1'b1;
          state_d = S_L_SCAN;
        end else if (cur_valid && !cur_seen) begin
          state_d = S_E_AGE;
        end else begin
          idx_inc = 1'b1;
        end
      end
      S_E_AGE: begin
        wr.miss_we = !evict;
        wr_miss    = miss_sat;
        idx_inc    = 1'b1;
        state_d    = S_E_SCAN;
      end
      S_L_SCAN: begin
        if (idx_end) begin
          if (min_found_q) begin
            idx_load = 1'b1;
            state_d  = S_L_RD;
          end else begin
            state_d  = S_L_EMPTY;
          end
        end else if (cur_valid && !listed_q[slot]) begin
          state_d = S_L_CHK;
        end else begin
          idx_inc = 1'b1;
        end
      end
      S_L_CHK: begin
        idx_inc = 1'b1;
        state_d = S_L_SCAN;
      end
      S_L_RD: state_d = S_L_OUT;
      S_L_OUT: begin
        em_kind = KIND_LIST;
        em_id   = rd_id;
        em_x    = t_x;
        em_y    = t_y;
        em_w    = t_w;
        em_h    = t_h;
        em_miss = rd_miss;
        em_cls  = rd_cls;
        em_last = !remaining;
        if (out_free) begin
          emit = 1'b1;
          if (remaining) begin
            idx_clr = 1'b1;
            state_d = S_L_SCAN;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_L_EMPTY: begin
        em_kind   = KIND_LIST;
        em_status = STAT_NONE;
        if (out_free) begin
          emit    = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_Q_SCAN: begin
        if (idx_end) begin
          state_d = S_Q_NONE;
        end else if (cur_valid) begin
          state_d = S_Q_CHK;
        end else begin
          idx_inc = 1'b1;
        end
      end
      S_Q_CHK: begin
        if (rd_id == qid_q) begin
          state_d = S_Q_OUT;
        end else begin
          idx_inc = 1'b1;
          state_d = S_Q_SCAN;
        end
      end
      S_Q_OUT: begin
        em_kind = KIND_QUERY;
        em_id   = rd_id;
        em_x    = t_x;
        em_y    = t_y;
        em_w    = t_w;
        em_h    = t_h;
        em_miss = rd_miss;
        em_cls  = rd_cls;
        if (out_free) begin
          emit    = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_Q_NONE: begin
        em_kind   = KIND_QUERY;
        em_status = STAT_NONE;
        if (out_free) begin
          emit    = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q        <= '0;
      thr_q        <= THR_RESET;
      maxm_q       <= MISS_LIMIT_RESET;
      valid_q      <= '0;
      seen_q       <= '0;
      listed_q     <= '0;
      next_id_q    <= '0;
      best_found_q <= 1'b0;
      coll_found_q <= 1'b0;
      min_found_q  <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_IOU_THRESHOLD: thr_q  <= cfg_data_i;
          CFG_MAX_MISSING:   maxm_q <= cfg_data_i[MISS_BITS-1:0];
          default:           thr_q  <= thr_q;
        endcase
      end

      if (idx_clr) begin
        idx_q <= '0;
      end else if (idx_load) begin
        idx_q <= CW'(min_slot_q);
      end else if (idx_inc) begin
        idx_q <= idx_q + CW'(1);
      end

      if (in_acc) begin
        best_found_q <= 1'b0;
        coll_found_q <= 1'b0;
      end
      if (state_q == S_D_GEOM && !coll_found_q && rd_id == next_id_q) begin
        coll_found_q <= 1'b1;
      end
      if ((state_q == S_MC && thr_pass && !best_found_q) ||
          (state_q == S_MQ && better)) begin
        best_found_q <= 1'b1;
      end

      if (state_q == S_D_DONE && out_free && !best_found_q && has_slot) begin
        valid_q[new_slot] <= 1'b1;
        seen_q[new_slot]  <= 1'b1;
        next_id_q         <= next_id_q + ID_BITS'(1);
      end
      if (state_q == S_D_DONE && out_free && best_found_q) begin
        seen_q[best_slot_q] <= 1'b1;
      end
      if (state_q == S_E_AGE && evict) begin
        valid_q[slot] <= 1'b0;
      end

      // end of the ageing pass starts a new frame and a fresh listing
      if (state_q == S_E_SCAN && idx_end) begin
        seen_q      <= '0;
        listed_q    <= '0;
        min_found_q <= 1'b0;
      end
      if (state_q == S_L_CHK && (!min_found_q || rd_id < min_id_q)) begin
        min_found_q <= 1'b1;
      end
      if (state_q == S_L_OUT && emit) begin
        listed_q[min_slot_q] <= 1'b1;
        min_found_q          <= 1'b0;
      end

      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      det_x_q   <= box_x_i;
      det_y_q   <= box_y_i;
      det_w_q   <= box_w_i;
      det_h_q   <= box_h_i;
      det_cls_q <= class_id_i;
      qid_q     <= query_id_i;
    end
    if (state_q == S_DA) begin
      da_q <= mul_p[MW-1:0];
    end
    if (state_q == S_D_GEOM) begin
      dx_q <= dxw[CB-1:0];
      dy_q <= dyw[CB-1:0];
    end
    if (state_q == S_D_GEOM && !coll_found_q) begin
      coll_slot_q <= slot;
    end
    if (state_q == S_MA) begin
      inter_q <= mul_p[MW-1:0];
    end
    if (state_q == S_MU) begin
      uni_q <= da_q + mul_p[MW-1:0] - inter_q;
    end
    if (state_q == S_MP) begin
      p1_q <= mul_p;
    end
    if ((state_q == S_MC && thr_pass && !best_found_q) ||
        (state_q == S_MQ && better)) begin
      best_slot_q <= slot;
      best_id_q   <= rd_id;
      best_i_q    <= inter_q;
      best_u_q    <= uni_q;
    end
    if (state_q == S_L_CHK && (!min_found_q || rd_id < min_id_q)) begin
      min_slot_q <= slot;
      min_id_q   <= rd_id;
    end
    if (emit) begin
      kind_q   <= em_kind;
      status_q <= em_status;
      id_q     <= em_id;
      ox_q     <= em_x;
      oy_q     <= em_y;
      ow_q     <= em_w;
      oh_q     <= em_h;
      cx_q     <= (CB+2)'({em_x, 1'b0}) + (CB+2)'(em_w);
      cy_q     <= (CB+2)'({em_y, 1'b0}) + (CB+2)'(em_h);
      omiss_q  <= em_miss;
      ocls_q   <= em_cls;
      olast_q  <= em_last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign kind_o          = kind_q;
  assign status_o        = status_q;
  assign track_id_o      = id_q;
  assign out_x_o         = ox_q;
  assign out_y_o         = oy_q;
  assign out_w_o         = ow_q;
  assign out_h_o         = oh_q;
  assign center_x2_o     = cx_q;
  assign center_y2_o     = cy_q;
  assign missing_count_o = omiss_q;
  assign out_class_o     = ocls_q;
  assign last_o          = olast_q;

endmodule
